### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the rtl/core blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

### rtl/core/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Types, codes and constants of the restart supervisor core
// ----------------------------------------------------------------------------
`default_nettype none

package rsf_pkg;

  // widths
  localparam int TIME_BITS  = 32;
  localparam int TIMER_BITS = 20;
  localparam int MAX_BITS   = 4;
  localparam int COUNT_BITS = 5;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;
  localparam int IN_BITS    = 8;
  localparam int OUT_BITS   = 16;

  // saturation value of the failure counter
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = 5'd16;

  // register reset values
  localparam logic [MAX_BITS-1:0]   BURST_MAX_RST = 4'd5;
  localparam logic [TIMER_BITS-1:0] WINDOW_RST    = 20'd60000;
  localparam logic [TIMER_BITS-1:0] BACKOFF_RST   = 20'd1000;
  localparam logic [TIMER_BITS-1:0] GRACE_RST     = 20'd3000;

  // event kinds
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_EXIT  = 3'd2,
    REQ_SPAWN = 3'd3,
    REQ_STOP  = 3'd4
  } req_t;

  // worker actions
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SPAWN = 2'd1,
    ACT_SOFT  = 2'd2,
    ACT_FORCE = 2'd3
  } action_t;

  // register word indexes
  typedef enum logic [1:0] {
    REG_BURST_MAX = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_BACKOFF   = 2'd2,
    REG_GRACE     = 2'd3
  } reg_idx_t;

  // one result beat
  typedef struct packed {
    logic                  exit_code;
    logic                  finished;
    logic [COUNT_BITS-1:0] attempt;
    logic                  recover_flag;
    action_t               action;
  } result_t;

  // timer load: a zero length counts as one tick
  function automatic logic [TIMER_BITS-1:0] load_timer(input logic [TIMER_BITS-1:0] ticks);
    load_timer = (ticks == '0) ? TIMER_BITS'(1) : ticks;
  endfunction

endpackage

`default_nettype wire

### rtl/core/restart_supervisor_fsm_core.sv
// ----------------------------------------------------------------------------
// restart_supervisor_fsm_core
// Event driven supervisor for one worker with restart, backoff and stop
// ----------------------------------------------------------------------------
// The core takes one event beat per cycle while the result side keeps
// draining and returns exactly one result beat for each. An event is held in
// an input register, and the whole state update for it (time counter, burst
// window, backoff and grace timers, worker flags) is done in one pass of
// compare and counter logic into the state and result registers, and a new
// event is taken every cycle as long as the result side keeps draining, at a
// rate set by that single state update. The user must write registers over the
// APB port only while no event is in flight; the core does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module restart_supervisor_fsm_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // event stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rsf_pkg::IN_BITS-1:0]   s_tdata,  // [0] exit_clean, [1] spawn_ok
  input  wire logic [2:0]                    s_tuser,  // [2:0] req_type
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rsf_pkg::OUT_BITS-1:0]       m_tdata,  // [1:0] action, [2] recover_flag,
                                                       // [7:3] attempt, [8] finished,
                                                       // [9] exit_code
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rsf_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [rsf_pkg::DATA_BITS-1:0] pwdata,
  output logic [rsf_pkg::DATA_BITS-1:0]      prdata,
  output logic                               pready
);

  localparam int TB = rsf_pkg::TIME_BITS;
  localparam int RB = rsf_pkg::TIMER_BITS;
  localparam int CB = rsf_pkg::COUNT_BITS;
  localparam int MB = rsf_pkg::MAX_BITS;

  // configuration registers
  logic [MB-1:0] burst_max;
  logic [RB-1:0] window_ticks;
  logic [RB-1:0] backoff_ticks;
  logic [RB-1:0] grace_ticks;
  logic          cfg_write;
  rsf_pkg::reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_idx   = rsf_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_max     <= rsf_pkg::BURST_MAX_RST;
      window_ticks  <= rsf_pkg::WINDOW_RST;
      backoff_ticks <= rsf_pkg::BACKOFF_RST;
      grace_ticks   <= rsf_pkg::GRACE_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        rsf_pkg::REG_BURST_MAX: burst_max     <= pwdata[MB-1:0];
        rsf_pkg::REG_WINDOW:    window_ticks  <= pwdata[RB-1:0];
        rsf_pkg::REG_BACKOFF:   backoff_ticks <= pwdata[RB-1:0];
        rsf_pkg::REG_GRACE:     grace_ticks   <= pwdata[RB-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      rsf_pkg::REG_BURST_MAX: prdata = {{(rsf_pkg::DATA_BITS-MB){1'b0}}, burst_max};
      rsf_pkg::REG_WINDOW:    prdata = {{(rsf_pkg::DATA_BITS-RB){1'b0}}, window_ticks};
      rsf_pkg::REG_BACKOFF:   prdata = {{(rsf_pkg::DATA_BITS-RB){1'b0}}, backoff_ticks};
      rsf_pkg::REG_GRACE:     prdata = {{(rsf_pkg::DATA_BITS-RB){1'b0}}, grace_ticks};
      default:                prdata = '0;
    endcase
  end

  // input register
  logic       in_valid;
  logic [2:0] in_req;
  logic       in_clean;
  logic       in_ok;
  logic       advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req   <= s_tuser;
      in_clean <= s_tdata[0];
      in_ok    <= s_tdata[1];
    end
  end

  // supervisor state
  logic [TB-1:0] now_count,      now_count_next;
  logic [TB-1:0] burst_start,    burst_start_next;
  logic [CB-1:0] fail_count,     fail_count_next;
  logic [RB-1:0] backoff_left,   backoff_left_next;
  logic          backoff_active, backoff_active_next;
  logic [RB-1:0] grace_left,     grace_left_next;
  logic          grace_active,   grace_active_next;
  logic          worker_alive,   worker_alive_next;
  logic          stopping_flag,  stopping_flag_next;
  logic          awaiting_spawn, awaiting_spawn_next;
  logic          done_flag,      done_flag_next;
  logic          final_status,   final_status_next;

  rsf_pkg::action_t act;
  logic             rec;
  logic [RB-1:0]    grace_dec;
  logic [RB-1:0]    backoff_dec;
  logic [TB-1:0]    elapsed;
  logic             window_over;
  logic [CB-1:0]    count_base;
  logic [CB-1:0]    count_inc;

  assign grace_dec   = grace_left - RB'(1);
  assign backoff_dec = backoff_left - RB'(1);
  assign elapsed     = now_count - burst_start;
  assign window_over = elapsed > {{(TB-RB){1'b0}}, window_ticks};
  assign count_base  = window_over ? '0 : fail_count;
  assign count_inc   = (count_base < rsf_pkg::COUNT_SAT) ? count_base + CB'(1) : count_base;

  // one event's state update
  always_comb begin
    now_count_next      = now_count;
    burst_start_next    = burst_start;
    fail_count_next     = fail_count;
    backoff_left_next   = backoff_left;
    backoff_active_next = backoff_active;
    grace_left_next     = grace_left;
    grace_active_next   = grace_active;
    worker_alive_next   = worker_alive;
    stopping_flag_next  = stopping_flag;
    awaiting_spawn_next = awaiting_spawn;
    done_flag_next      = done_flag;
    final_status_next   = final_status;
    act                 = rsf_pkg::ACT_NONE;
    rec                 = 1'b0;

    if (!done_flag) begin
      unique case (in_req)
        rsf_pkg::REQ_TICK: begin
          now_count_next = now_count + TB'(1);
          if (grace_active) begin
            grace_left_next = grace_dec;
            if (grace_dec == '0) begin
              grace_active_next = 1'b0;
              if (worker_alive) act = rsf_pkg::ACT_FORCE;
            end
          end
          if (backoff_active && act == rsf_pkg::ACT_NONE) begin
            backoff_left_next = backoff_dec;
            if (backoff_dec == '0) begin
              backoff_active_next = 1'b0;
              if (!stopping_flag) begin
                act                 = rsf_pkg::ACT_SPAWN;
                rec                 = 1'b1;
                awaiting_spawn_next = 1'b1;
              end
            end
          end
        end
        rsf_pkg::REQ_START: begin
          if (!worker_alive && !awaiting_spawn && !backoff_active && !stopping_flag) begin
            burst_start_next    = now_count;
            awaiting_spawn_next = 1'b1;
            act                 = rsf_pkg::ACT_SPAWN;
          end
        end
        rsf_pkg::REQ_EXIT: begin
          if (worker_alive) begin
            worker_alive_next = 1'b0;
            if (stopping_flag || in_clean) begin
              done_flag_next      = 1'b1;
              final_status_next   = 1'b0;
              backoff_active_next = 1'b0;
              grace_active_next   = 1'b0;
              awaiting_spawn_next = 1'b0;
            end else begin
              // unclean exit: count it in the burst window
              if (window_over) burst_start_next = now_count;
              fail_count_next = count_inc;
              if (count_inc > {1'b0, burst_max}) begin
                done_flag_next      = 1'b1;
                final_status_next   = 1'b1;
                backoff_active_next = 1'b0;
                grace_active_next   = 1'b0;
                awaiting_spawn_next = 1'b0;
              end else begin
                backoff_left_next   = rsf_pkg::load_timer(backoff_ticks);
                backoff_active_next = 1'b1;
              end
            end
          end
        end
        rsf_pkg::REQ_SPAWN: begin
          if (awaiting_spawn) begin
            awaiting_spawn_next = 1'b0;
            if (in_ok) begin
              worker_alive_next = 1'b1;
            end else begin
              done_flag_next      = 1'b1;
              final_status_next   = 1'b1;
              backoff_active_next = 1'b0;
              grace_active_next   = 1'b0;
            end
          end
        end
        rsf_pkg::REQ_STOP: begin
          if (!stopping_flag) begin
            stopping_flag_next = 1'b1;
            final_status_next  = 1'b0;
            if (worker_alive) begin
              act               = rsf_pkg::ACT_SOFT;
              grace_left_next   = rsf_pkg::load_timer(grace_ticks);
              grace_active_next = 1'b1;
            end else begin
              done_flag_next      = 1'b1;
              backoff_active_next = 1'b0;
              grace_active_next   = 1'b0;
              awaiting_spawn_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      now_count      <= '0;
      burst_start    <= '0;
      fail_count     <= '0;
      backoff_left   <= '0;
      backoff_active <= 1'b0;
      grace_left     <= '0;
      grace_active   <= 1'b0;
      worker_alive   <= 1'b0;
      stopping_flag  <= 1'b0;
      awaiting_spawn <= 1'b0;
      done_flag      <= 1'b0;
      final_status   <= 1'b0;
    end else if (advance) begin
      now_count      <= now_count_next;
      burst_start    <= burst_start_next;
      fail_count     <= fail_count_next;
      backoff_left   <= backoff_left_next;
      backoff_active <= backoff_active_next;
      grace_left     <= grace_left_next;
      grace_active   <= grace_active_next;
      worker_alive   <= worker_alive_next;
      stopping_flag  <= stopping_flag_next;
      awaiting_spawn <= awaiting_spawn_next;
      done_flag      <= done_flag_next;
      final_status   <= final_status_next;
    end
  end

  // result register
  rsf_pkg::result_t res;

  always_comb begin
    res.action       = act;
    res.recover_flag = rec;
    res.attempt      = fail_count_next;
    res.finished     = done_flag_next;
    res.exit_code    = done_flag_next && final_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(rsf_pkg::OUT_BITS-$bits(rsf_pkg::result_t)){1'b0}}, res};
    end
  end

  // checks
  `ASSERT_NEXT(a_done_sticks, clk, rst, done_flag, done_flag,
    "supervision left the finished state")
  `ASSERT_ALWAYS(a_alive_no_backoff, clk, rst, !(worker_alive && backoff_active),
    "backoff running while a worker is alive")
  `ASSERT_ALWAYS(a_count_bound, clk, rst, fail_count <= rsf_pkg::COUNT_SAT,
    "failure count above saturation")
  `ASSERT_IMPLIES(a_recover_spawn, clk, rst, m_tvalid && m_tdata[2],
    m_tdata[1:0] == rsf_pkg::ACT_SPAWN, "recovery flag without a spawn")
  `ASSERT_IMPLIES(a_exit_code, clk, rst, m_tvalid && m_tdata[9], m_tdata[8],
    "exit status reported before finishing")

endmodule

`default_nettype wire

### bench/restart_supervisor_fsm_core_tb.sv
// ----------------------------------------------------------------------------
// restart_supervisor_fsm_core_tb
// Self-checking bench for the restart supervisor core
// ----------------------------------------------------------------------------
// Drives event beats into the core and keeps its own copy of the supervisor
// state. Every accepted event produces one expected result, and the results
// are compared field by field in order. There is one reset, so the whole run
// is one supervision session. A directed part covers the ignored events,
// start, respawn and the burst window. Random phases under several register
// settings follow, with events chosen from the current state so the worker
// keeps cycling through spawn, failure and backoff. A randomly chosen way of
// ending supervision closes the run, followed by events that must be ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module restart_supervisor_fsm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ways to close the session
  typedef enum int {
    END_STOP_LIVE,
    END_CLEAN_EXIT,
    END_SPAWN_FAIL,
    END_STOP_IDLE,
    END_GIVE_UP
  } ending_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [rsf_pkg::IN_BITS-1:0]   s_tdata;   // [0] exit_clean, [1] spawn_ok
  logic [2:0]                    s_tuser;   // [2:0] req_type
  logic                          m_tvalid;
  logic                          m_tready;
  logic [rsf_pkg::OUT_BITS-1:0]  m_tdata;   // [1:0] action, [2] recover_flag,
                                            // [7:3] attempt, [8] finished,
                                            // [9] exit_code
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rsf_pkg::ADDR_BITS-1:0] paddr;
  logic [rsf_pkg::DATA_BITS-1:0] pwdata;
  logic [rsf_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  // register copies
  logic [rsf_pkg::MAX_BITS-1:0]   cfg_burst_max = rsf_pkg::BURST_MAX_RST;
  logic [rsf_pkg::TIMER_BITS-1:0] cfg_window    = rsf_pkg::WINDOW_RST;
  logic [rsf_pkg::TIMER_BITS-1:0] cfg_backoff   = rsf_pkg::BACKOFF_RST;
  logic [rsf_pkg::TIMER_BITS-1:0] cfg_grace     = rsf_pkg::GRACE_RST;

  // supervisor state copy
  logic [rsf_pkg::TIME_BITS-1:0]  now_q         = '0;
  logic [rsf_pkg::TIME_BITS-1:0]  burst_start_q = '0;
  logic [rsf_pkg::COUNT_BITS-1:0] fail_cnt      = '0;
  logic [rsf_pkg::TIMER_BITS-1:0] backoff_left  = '0;
  logic [rsf_pkg::TIMER_BITS-1:0] grace_left    = '0;
  bit backoff_on = 0;
  bit grace_on   = 0;
  bit alive      = 0;
  bit stopping   = 0;
  bit awaiting   = 0;
  bit done       = 0;
  bit final_st   = 0;

  rsf_pkg::result_t pending[$];
  int      errors      = 0;
  bit      src_steady  = 0;
  bit      sink_steady = 0;

  restart_supervisor_fsm_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // supervisor prediction
  // ---------------------------------------------------------------------------

  function automatic void end_supervision(bit status);
    done       = 1;
    final_st   = status;
    backoff_on = 0;
    grace_on   = 0;
    awaiting   = 0;
  endfunction

  // failure count after one more failure, window restart included
  function automatic logic [rsf_pkg::COUNT_BITS-1:0] count_after_failure();
    logic [rsf_pkg::COUNT_BITS-1:0] n;
    n = (now_q - burst_start_q > cfg_window) ? '0 : fail_cnt;
    if (n < rsf_pkg::COUNT_SAT) n = n + rsf_pkg::COUNT_BITS'(1);
    return n;
  endfunction

  function automatic void count_failure();
    logic [rsf_pkg::COUNT_BITS-1:0] n;
    n = count_after_failure();
    if (now_q - burst_start_q > cfg_window) burst_start_q = now_q;
    fail_cnt = n;
    if (n > cfg_burst_max) begin
      end_supervision(1);
    end else begin
      backoff_left = (cfg_backoff == '0) ? rsf_pkg::TIMER_BITS'(1) : cfg_backoff;
      backoff_on   = 1;
    end
  endfunction

  function automatic rsf_pkg::result_t step_supervisor(logic [2:0] kind, bit clean, bit ok);
    rsf_pkg::result_t r;
    r = '0;
    if (!done) begin
      case (kind)
        rsf_pkg::REQ_TICK: begin
          now_q = now_q + rsf_pkg::TIME_BITS'(1);
          if (grace_on) begin
            grace_left = grace_left - rsf_pkg::TIMER_BITS'(1);
            if (grace_left == '0) begin
              grace_on = 0;
              if (alive) r.action = rsf_pkg::ACT_FORCE;
            end
          end
          if (backoff_on && r.action == rsf_pkg::ACT_NONE) begin
            backoff_left = backoff_left - rsf_pkg::TIMER_BITS'(1);
            if (backoff_left == '0) begin
              backoff_on = 0;
              if (!stopping) begin
                r.action       = rsf_pkg::ACT_SPAWN;
                r.recover_flag = 1'b1;
                awaiting       = 1;
              end
            end
          end
        end
        rsf_pkg::REQ_START: begin
          if (!alive && !awaiting && !backoff_on && !stopping) begin
            burst_start_q = now_q;
            awaiting      = 1;
            r.action      = rsf_pkg::ACT_SPAWN;
          end
        end
        rsf_pkg::REQ_EXIT: begin
          if (alive) begin
            alive = 0;
            if (stopping || clean) end_supervision(0);
            else count_failure();
          end
        end
        rsf_pkg::REQ_SPAWN: begin
          if (awaiting) begin
            awaiting = 0;
            if (ok) alive = 1;
            else end_supervision(1);
          end
        end
        rsf_pkg::REQ_STOP: begin
          if (!stopping) begin
            stopping = 1;
            final_st = 0;
            if (alive) begin
              r.action   = rsf_pkg::ACT_SOFT;
              grace_left = (cfg_grace == '0) ? rsf_pkg::TIMER_BITS'(1) : cfg_grace;
              grace_on   = 1;
            end else begin
              end_supervision(0);
            end
          end
        end
        default: ;
      endcase
    end
    r.attempt   = fail_cnt;
    r.finished  = done;
    r.exit_code = done && final_st;
    return r;
  endfunction

  // true for a stop, clean exit, failed spawn, give-up or backoff over 64
  function automatic bit ends_session(logic [2:0] kind, bit clean, bit ok);
    if (done) return 0;
    case (kind)
      rsf_pkg::REQ_STOP:  return 1;
      rsf_pkg::REQ_EXIT:  return alive && (clean || count_after_failure() > cfg_burst_max ||
                                           cfg_backoff > 64);
      rsf_pkg::REQ_SPAWN: return awaiting && !ok;
      default:            return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one event beat, predicted when it is taken
  task automatic send_event(logic [2:0] kind, bit clean, bit ok);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= rsf_pkg::IN_BITS'({ok, clean});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending.push_back(step_supervisor(kind, clean, ok));
  endtask

  // stop sending and let every result come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, upper bits sometimes filled with junk
  task automatic write_reg(rsf_pkg::reg_idx_t idx, logic [rsf_pkg::DATA_BITS-1:0] value);
    logic [rsf_pkg::DATA_BITS-1:0] word;
    word = value;
    if ($urandom_range(0, 1) == 1) begin
      word = (idx == rsf_pkg::REG_BURST_MAX) ? (value | ($urandom & ~32'hF)) :
                                               (value | ($urandom & ~32'hFFFFF));
    end
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rsf_pkg::ADDR_BITS'({idx, 2'b00});
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      rsf_pkg::REG_BURST_MAX: cfg_burst_max = word[rsf_pkg::MAX_BITS-1:0];
      rsf_pkg::REG_WINDOW:    cfg_window    = word[rsf_pkg::TIMER_BITS-1:0];
      rsf_pkg::REG_BACKOFF:   cfg_backoff   = word[rsf_pkg::TIMER_BITS-1:0];
      rsf_pkg::REG_GRACE:     cfg_grace     = word[rsf_pkg::TIMER_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(int bmax, int win, int boff, int grace);
    wait_drained();
    write_reg(rsf_pkg::REG_BURST_MAX, bmax);
    write_reg(rsf_pkg::REG_WINDOW, win);
    write_reg(rsf_pkg::REG_BACKOFF, boff);
    write_reg(rsf_pkg::REG_GRACE, grace);
  endtask

  // state-driven traffic that keeps the session alive, with some noise
  task automatic run_phase(int n);
    logic [2:0] kind;
    bit         clean;
    bit         ok;
    int         roll;
    repeat (n) begin
      kind  = rsf_pkg::REQ_TICK;
      clean = 1'($urandom_range(0, 1));
      ok    = 1'($urandom_range(0, 1));
      roll  = $urandom_range(0, 99);
      if (roll < 15) begin
        kind = 3'($urandom_range(0, 7));
      end else if (awaiting) begin
        if (roll < 70) begin
          kind = rsf_pkg::REQ_SPAWN;
          ok   = 1'b1;
        end
      end else if (alive) begin
        if (roll < 40) begin
          kind  = rsf_pkg::REQ_EXIT;
          clean = 1'b0;
        end
      end else if (!backoff_on && !stopping) begin
        kind = rsf_pkg::REQ_START;
      end
      if (ends_session(kind, clean, ok)) kind = rsf_pkg::REQ_TICK;
      send_event(kind, clean, ok);
    end
  endtask

  // walk the session until the worker runs
  task automatic reach_alive();
    while (!alive) begin
      if (awaiting) begin
        send_event(rsf_pkg::REQ_SPAWN, 1'($urandom_range(0, 1)), 1'b1);
      end else if (backoff_on) begin
        send_event(rsf_pkg::REQ_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_event(rsf_pkg::REQ_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // events with nothing to act on
  task automatic test_ignored_events();
    send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b1);
    send_event(rsf_pkg::REQ_EXIT, 1'b1, 1'b0);
    send_event(rsf_pkg::REQ_SPAWN, 1'b0, 1'b1);
    send_event(rsf_pkg::REQ_SPAWN, 1'b1, 1'b0);
    for (int k = rsf_pkg::REQ_STOP + 1; k < 8; k++) send_event(3'(k), 1'b1, 1'b1);
  endtask

  // first spawn and repeated starts
  task automatic test_start_and_spawn();
    send_event(rsf_pkg::REQ_START, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_START, 1'b1, 1'b1);
    send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_SPAWN, 1'b0, 1'b1);
    send_event(rsf_pkg::REQ_START, 1'b0, 1'b0);
  endtask

  // failure, zero backoff, recovery spawn and window restart
  task automatic test_restart_window();
    apply_settings(2, 2, 0, 0);
    send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_START, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_SPAWN, 1'b0, 1'b1);
    send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b1);
    send_event(rsf_pkg::REQ_TICK, 1'b1, 1'b0);
    send_event(rsf_pkg::REQ_SPAWN, 1'b1, 1'b1);
    send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
    send_event(rsf_pkg::REQ_SPAWN, 1'b0, 1'b1);
  endtask

  // random traffic under several register settings
  task automatic test_random_traffic();
    apply_settings(15, 3, 2, 2);
    run_phase(100);
    apply_settings(3, 40, 1, 5);
    run_phase(100);
    repeat (4) begin
      apply_settings($urandom_range(1, 15), $urandom_range(0, 60),
                     $urandom_range(0, 8), $urandom_range(0, 8));
      run_phase(100);
    end
  endtask

  // largest and smallest register values
  task automatic test_extreme_settings();
    apply_settings(15, 'hFFFFF, 'hFFFFF, 'hFFFFF);
    run_phase(40);
    apply_settings(0, 0, 0, 0);
    run_phase(40);
  endtask

  // close supervision one way, chosen at random
  task automatic test_ending();
    ending_t how;
    how = ending_t'($urandom_range(0, 4));
    apply_settings($urandom_range(0, 1) ? 15 : 1,
                   (how == END_GIVE_UP) ? 'hFFFFF : 1, 1, 3);
    case (how)
      END_STOP_LIVE: begin
        reach_alive();
        send_event(rsf_pkg::REQ_STOP, 1'b0, 1'b0);
        send_event(rsf_pkg::REQ_STOP, 1'b1, 1'b1);
        repeat (5) send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
        send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b0);
      end
      END_CLEAN_EXIT: begin
        reach_alive();
        send_event(rsf_pkg::REQ_EXIT, 1'b1, 1'b0);
      end
      END_SPAWN_FAIL: begin
        reach_alive();
        repeat (2) send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
        send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b0);
        while (!awaiting) send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
        send_event(rsf_pkg::REQ_SPAWN, 1'b1, 1'b0);
      end
      END_STOP_IDLE: begin
        reach_alive();
        repeat (2) send_event(rsf_pkg::REQ_TICK, 1'b0, 1'b0);
        send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'b0);
        send_event(rsf_pkg::REQ_STOP, 1'b0, 1'b0);
      end
      default: begin
        while (!done) begin
          reach_alive();
          send_event(rsf_pkg::REQ_EXIT, 1'b0, 1'($urandom_range(0, 1)));
        end
      end
    endcase
  endtask

  // every event is ignored once supervision is over
  task automatic test_after_finish();
    repeat (12) begin
      send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready with random stalls per beat
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = sink_steady ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    rsf_pkg::result_t got;
    rsf_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(rsf_pkg::result_t)-1:0];
      if (pending.size() == 0) begin
        $error("result beat with no event outstanding");
        errors++;
      end else begin
        want = pending.pop_front();
        check_field("action", want.action, got.action);
        check_field("recover_flag", want.recover_flag, got.recover_flag);
        check_field("attempt", want.attempt, got.attempt);
        check_field("finished", want.finished, got.finished);
        check_field("exit_code", want.exit_code, got.exit_code);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ignored_events();
    test_start_and_spawn();
    test_restart_window();
    test_random_traffic();
    test_extreme_settings();
    test_ending();
    test_after_finish();
    wait_drained();
    repeat (6) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### restart_supervisor_fsm_core.f
+incdir+rtl/core
rtl/core/rsf_pkg.sv
rtl/core/restart_supervisor_fsm_core.sv
bench/restart_supervisor_fsm_core_tb.sv
